// File: rtl/lbs_pkg.sv
// Package for the linked box sequence engine: widths, operation codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package lbs_pkg;
  localparam int unsigned MaxBoxesDefault = 1024;
  localparam int unsigned BoxW = 11;
  localparam int unsigned SumW = 20;
  localparam int unsigned OpW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_MOVE_LEFT  = 3'd0,
    OP_MOVE_RIGHT = 3'd1,
    OP_SWAP       = 3'd2,
    OP_REVERSE    = 3'd3,
    OP_QUERY      = 3'd4,
    OP_RESTART    = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_Y,
    ST_RD_X,
    ST_CHECK,
    ST_WRITE,
    ST_REBUILD,
    ST_QUERY,
    ST_QWAIT,
    ST_FINISH,
    ST_OUT
  } state_e;
endpackage

// File: rtl/linked_box_sequence_engine.sv
// Linked box sequence engine top level: link memories and command sequencer.
// Depends on lbs_pkg.
// Move/swap reads the links of box y, then of box x, and writes three or four joins,
// one per cycle; an unchanged move or a bad box writes nothing; reverse toggles a flag;
// restart rebuilds the ring; query walks it and holds the sum until taken. One command
// at a time. Reset: a pass over the store writes the ring 0..MAX_BOXES (then any smaller
// reset-count ring), accepting no command. Configuration writes are taken at any time.
`timescale 1ns / 1ps
module linked_box_sequence_engine import lbs_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [BoxW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OpW-1:0]  operation_i,
  input  logic [BoxW-1:0] box_x_i,
  input  logic [BoxW-1:0] box_y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SumW-1:0] odd_position_sum_o
);
  localparam int unsigned AW = $clog2(MAX_BOXES + 1);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1) + 1;
  localparam logic [CW-1:0] MaxC = CW'(MAX_BOXES);
  localparam logic [CW-1:0] ResetCnt = (MAX_BOXES >= 1024) ? CW'(1024) : MaxC;
  localparam logic [CW+BoxW-1:0] MaxW = (CW+BoxW)'(MAX_BOXES);
  localparam int unsigned TW = 2 * CW;

  logic [AW-1:0] rl_mem [MAX_BOXES+1];
  logic [AW-1:0] ll_mem [MAX_BOXES+1];

  state_e state_q, state_d;
  logic [CW-1:0] boxcnt_q, boxcnt_d, actcnt_q, actcnt_d;
  logic rev_q, rev_d;
  logic [OpW-1:0] op_q, op_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [AW-1:0] lx_q, lx_d, rx_q, rx_d, ly_q, ly_d, ry_q, ry_d;
  logic [1:0] wcnt_q, wcnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [SumW-1:0] sum_q, sum_d, res_q, res_d;
  logic [TW-1:0] tot_q, tot_d;
  logic [1:0] rphase_q, rphase_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rl_rd_q, ll_rd_q;
  logic          we_r, we_l;
  logic [AW-1:0] wa_r, wd_r, wa_l, wd_l;

  always_ff @(posedge clk_i) begin
    if (we_r) rl_mem[wa_r] <= wd_r;
    if (we_l) ll_mem[wa_l] <= wd_l;
    if (rd_en) begin
      rl_rd_q <= rl_mem[rd_addr];
      ll_rd_q <= ll_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_REBUILD;
      boxcnt_q <= ResetCnt;
      actcnt_q <= ResetCnt;
      rev_q    <= 1'b0;
      idx_q    <= '0;
      rphase_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      boxcnt_q <= boxcnt_d;
      actcnt_q <= actcnt_d;
      rev_q    <= rev_d;
      idx_q    <= idx_d;
      rphase_q <= rphase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; x_q <= x_d; y_q <= y_d;
    lx_q <= lx_d; rx_q <= rx_d; ly_q <= ly_d; ry_q <= ry_d;
    wcnt_q <= wcnt_d; pos_q <= pos_d; sum_q <= sum_d; res_q <= res_d;
    tot_q <= tot_d;
  end

  logic [CW+BoxW-1:0] cfg_wide, bx_wide, by_wide;
  assign cfg_wide = {{CW{1'b0}}, cfg_wdata_i};
  assign bx_wide  = {{CW{1'b0}}, box_x_i};
  assign by_wide  = {{CW{1'b0}}, box_y_i};

  logic [CW-1:0] cfg_clip;
  always_comb begin
    cfg_clip = cfg_wide[CW-1:0];
    if (cfg_wdata_i == '0) cfg_clip = CW'(1);
    else if (cfg_wide > MaxW) cfg_clip = MaxC;
  end

  logic bad;
  logic [AW-1:0] ja, jb;
  logic          jv;

  always_comb begin
    state_d = state_q;
    boxcnt_d = cfg_we_i ? cfg_clip : boxcnt_q;
    actcnt_d = actcnt_q; rev_d = rev_q;
    op_d = op_q; x_d = x_q; y_d = y_q;
    lx_d = lx_q; rx_d = rx_q; ly_d = ly_q; ry_d = ry_q;
    wcnt_d = wcnt_q; idx_d = idx_q; pos_d = pos_q; sum_d = sum_q; res_d = res_q;
    tot_d = tot_q; rphase_d = rphase_q;
    rd_en = 1'b0; rd_addr = '0;
    ja = '0; jb = '0; jv = 1'b0;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    bad = (x_q == '0) || (y_q == '0) || (x_q == y_q) || (x_q > actcnt_q) ||
          (y_q > actcnt_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d = operation_i;
          x_d = (bx_wide > MaxW) ? '0 : bx_wide[CW-1:0];
          y_d = (by_wide > MaxW) ? '0 : by_wide[CW-1:0];
          case (op_e'(operation_i))
            OP_REVERSE: rev_d = !rev_q;
            OP_QUERY: begin
              idx_d = CW'(1); pos_d = '0; sum_d = '0;
              rd_en = 1'b1; rd_addr = '0;
              tot_d = TW'(actcnt_q) * TW'(actcnt_q + CW'(1));
              state_d = ST_QUERY;
            end
            OP_RESTART: begin
              actcnt_d = boxcnt_q; idx_d = '0; rphase_d = 2'd1;
              state_d = ST_REBUILD;
            end
            OP_MOVE_LEFT, OP_MOVE_RIGHT, OP_SWAP: state_d = ST_RD_Y;
            default: ;
          endcase
        end
      end
      ST_RD_Y: begin
        if (bad) state_d = ST_IDLE;
        else begin
          rd_en = 1'b1; rd_addr = y_q[AW-1:0]; state_d = ST_RD_X;
        end
      end
      ST_RD_X: begin
        ly_d = ll_rd_q; ry_d = rl_rd_q;
        rd_en = 1'b1; rd_addr = x_q[AW-1:0];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        lx_d = ll_rd_q; rx_d = rl_rd_q; wcnt_d = '0;
        state_d = ST_WRITE;
        if (op_e'(op_q) == OP_SWAP) begin
          if (ry_q == x_q[AW-1:0]) begin
            x_d = y_q; y_d = x_q;
            lx_d = ly_q; rx_d = ry_q; ly_d = ll_rd_q; ry_d = rl_rd_q;
          end
        end else begin
          if (rev_q) op_d = {2'b00, ~op_q[0]};
          if ((op_q[0] ^ rev_q) == 1'b0 && ly_q == x_q[AW-1:0]) state_d = ST_IDLE;
          if ((op_q[0] ^ rev_q) == 1'b1 && ry_q == x_q[AW-1:0]) state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        jv = 1'b1;
        wcnt_d = wcnt_q + 2'd1;
        case (op_e'(op_q))
          OP_MOVE_LEFT: begin
            case (wcnt_q)
              2'd0: begin ja = lx_q; jb = rx_q; end
              2'd1: begin ja = ly_q; jb = x_q[AW-1:0]; end
              default: begin ja = x_q[AW-1:0]; jb = y_q[AW-1:0]; end
            endcase
            if (wcnt_q == 2'd2) state_d = ST_IDLE;
          end
          OP_MOVE_RIGHT: begin
            case (wcnt_q)
              2'd0: begin ja = lx_q; jb = rx_q; end
              2'd1: begin ja = y_q[AW-1:0]; jb = x_q[AW-1:0]; end
              default: begin ja = x_q[AW-1:0]; jb = ry_q; end
            endcase
            if (wcnt_q == 2'd2) state_d = ST_IDLE;
          end
          default: begin
            if (rx_q == y_q[AW-1:0]) begin
              case (wcnt_q)
                2'd0: begin ja = lx_q; jb = y_q[AW-1:0]; end
                2'd1: begin ja = y_q[AW-1:0]; jb = x_q[AW-1:0]; end
                default: begin ja = x_q[AW-1:0]; jb = ry_q; end
              endcase
              if (wcnt_q == 2'd2) state_d = ST_IDLE;
            end else begin
              case (wcnt_q)
                2'd0: begin ja = lx_q; jb = y_q[AW-1:0]; end
                2'd1: begin ja = y_q[AW-1:0]; jb = rx_q; end
                2'd2: begin ja = ly_q; jb = x_q[AW-1:0]; end
                default: begin ja = x_q[AW-1:0]; jb = ry_q; end
              endcase
              if (wcnt_q == 2'd3) state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_REBUILD: begin
        // rphase 0: reset pass over the whole store, then reset-count ring
        jv = 1'b1;
        if (rphase_q == 2'd0) begin
          ja = idx_q[AW-1:0];
          jb = (idx_q == MaxC) ? '0 : AW'(idx_q + CW'(1));
          if (idx_q == MaxC) begin
            idx_d = '0; rphase_d = 2'd1;
            if (actcnt_q == MaxC) state_d = ST_IDLE;
          end else idx_d = idx_q + CW'(1);
        end else begin
          ja = idx_q[AW-1:0];
          jb = (idx_q == actcnt_q) ? '0 : AW'(idx_q + CW'(1));
          if (idx_q == actcnt_q) begin
            rev_d = 1'b0; state_d = ST_IDLE;
          end else idx_d = idx_q + CW'(1);
        end
      end
      ST_QUERY: begin
        pos_d = rl_rd_q;
        if (idx_q[0]) sum_d = sum_q + SumW'(rl_rd_q);
        rd_en = 1'b1; rd_addr = rl_rd_q;
        if (idx_q == actcnt_q) state_d = ST_FINISH;
        else idx_d = idx_q + CW'(1);
      end
      ST_FINISH: begin
        res_d = sum_q;
        if (rev_q && !actcnt_q[0]) begin
          if (TW'(sum_q) > (tot_q >> 1)) res_d = '0;
          else res_d = SumW'((tot_q >> 1) - TW'(sum_q));
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    we_r = jv; wa_r = ja; wd_r = jb;
    we_l = jv; wa_l = jb; wd_l = ja;
  end

  assign odd_position_sum_o = res_q;

  logic unused;
  assign unused = ^{pos_q, rphase_q[1], ST_QWAIT};
endmodule

// File: rtl/lbs_checker.sv
// Port-level checker for the linked box sequence engine, bound to the top level.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_checker import lbs_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic [OpW-1:0]  operation_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [SumW-1:0] odd_position_sum_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(odd_position_sum_o))
    else $error("result beat dropped or changed while stalled");
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");
  a_query_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_QUERY |=> !out_valid_o)
    else $error("query result too early");
  a_nonquery_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i != OP_QUERY |=> !out_valid_o)
    else $error("result from non-query");
endmodule

bind linked_box_sequence_engine lbs_checker u_lbs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i,
  .out_valid_o, .out_ready_i, .odd_position_sum_o
);

// File: verif/lbs_sum_checker.sv
// Checker for the linked box sequence engine: follows configuration and
// command beats, keeps its own link tables and compares query sums.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_sum_checker import lbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [BoxW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [OpW-1:0]  operation_i,
  input  logic [BoxW-1:0] box_x_i,
  input  logic [BoxW-1:0] box_y_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [SumW-1:0] odd_position_sum_i,
  output int              fail_count_o,
  output int              sums_pending_o
);
  localparam int unsigned MaxBoxes = MaxBoxesDefault;

  logic [BoxW-1:0] right_of [0:MaxBoxes];
  logic [BoxW-1:0] left_of  [0:MaxBoxes];
  logic            line_reversed;
  int unsigned     staged_count;
  int unsigned     line_count;
  logic [SumW-1:0] sum_expected [$];

  task automatic link_boxes(input int unsigned a, input int unsigned b);
    right_of[a] = BoxW'(b);
    left_of[b]  = BoxW'(a);
  endtask

  task automatic rebuild_line();
    line_count = staged_count;
    for (int unsigned i = 0; i < line_count; i++) link_boxes(i, i + 1);
    link_boxes(line_count, 0);
    line_reversed = 1'b0;
  endtask

  function automatic logic [SumW-1:0] odd_sum();
    int unsigned pos;
    longint unsigned sum, total;
    pos = 0;
    sum = 0;
    for (int unsigned i = 1; i <= line_count; i++) begin
      pos = right_of[pos];
      if (i[0]) sum += pos;
    end
    if (line_reversed && !line_count[0]) begin
      total = longint'(line_count) * (line_count + 1) / 2;
      sum = (sum > total) ? 0 : total - sum;
    end
    return SumW'(sum);
  endfunction

  task automatic apply_box_command(input logic [OpW-1:0] op, input int unsigned bx,
                                   input int unsigned by);
    int unsigned lx, rx, ly, ry, t;
    logic [OpW-1:0] mop;
    mop = op;
    case (op)
      OP_REVERSE: line_reversed = !line_reversed;
      OP_QUERY:   sum_expected.push_back(odd_sum());
      OP_RESTART: rebuild_line();
      OP_MOVE_LEFT, OP_MOVE_RIGHT, OP_SWAP: begin
        if (bx == 0 || by == 0 || bx == by || bx > line_count || by > line_count) return;
        if (op == OP_SWAP && right_of[by] == bx) begin
          t = bx; bx = by; by = t;
        end
        if (op != OP_SWAP && line_reversed)
          mop = (op == OP_MOVE_LEFT) ? OP_MOVE_RIGHT : OP_MOVE_LEFT;
        if (mop == OP_MOVE_LEFT && left_of[by] == bx) return;
        if (mop == OP_MOVE_RIGHT && right_of[by] == bx) return;
        lx = left_of[bx]; rx = right_of[bx];
        ly = left_of[by]; ry = right_of[by];
        if (mop == OP_MOVE_LEFT) begin
          link_boxes(lx, rx); link_boxes(ly, bx); link_boxes(bx, by);
        end else if (mop == OP_MOVE_RIGHT) begin
          link_boxes(lx, rx); link_boxes(by, bx); link_boxes(bx, ry);
        end else if (rx == by) begin
          link_boxes(lx, by); link_boxes(by, bx); link_boxes(bx, ry);
        end else begin
          link_boxes(lx, by); link_boxes(by, rx); link_boxes(ly, bx); link_boxes(bx, ry);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_count = MaxBoxes;
      rebuild_line();
      sum_expected.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        staged_count = (cfg_wdata_i == 0) ? 1 :
                       (cfg_wdata_i > MaxBoxes) ? MaxBoxes : cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) apply_box_command(operation_i, box_x_i, box_y_i);
      if (out_valid_i && out_ready_i) begin
        if (sum_expected.size() == 0) begin
          $error("odd_position_sum: unexpected beat, actual %0d", odd_position_sum_i);
          fail_count_o++;
        end else if (odd_position_sum_i !== sum_expected[0]) begin
          $error("odd_position_sum: expected %0d, actual %0d", sum_expected[0],
                 odd_position_sum_i);
          fail_count_o++;
          void'(sum_expected.pop_front());
        end else begin
          void'(sum_expected.pop_front());
        end
      end
    end
    sums_pending_o = sum_expected.size();
  end
endmodule

// File: verif/tb_linked_box_sequence_engine.sv
// Testbench top for the linked box sequence engine: clock, reset, command
// and configuration stimulus, verdict. Depends on lbs_pkg, linked_box_sequence_engine and lbs_sum_checker.
`timescale 1ns / 1ps
module tb_linked_box_sequence_engine;
  import lbs_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [BoxW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [OpW-1:0]  operation_i = '0;
  logic [BoxW-1:0] box_x_i = '0;
  logic [BoxW-1:0] box_y_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [SumW-1:0] odd_position_sum_o;
  int              fail_count, sums_pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int idle_cycles = 0;
  int unsigned line_count = MaxBoxesDefault;

  linked_box_sequence_engine dut (.*);

  lbs_sum_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .operation_i, .box_x_i, .box_y_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .odd_position_sum_i(odd_position_sum_o),
    .fail_count_o(fail_count), .sums_pending_o(sums_pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(input logic [OpW-1:0] op, input int unsigned bx,
                              input int unsigned by);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    box_x_i     <= BoxW'(bx);
    box_y_i     <= BoxW'(by);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // quiesce, then write box_count and, if restart is set, restart so it takes effect
  task automatic set_box_count(input int unsigned value, input bit restart);
    in_valid_i <= 1'b0;
    wait (sums_pending == 0);
    @(posedge clk_i);
    repeat (line_count + 20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= BoxW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (restart) begin
      line_count = (value == 0) ? 1 : (value > MaxBoxesDefault) ? MaxBoxesDefault : value;
      send_command(OP_RESTART, 0, 0);
    end
  endtask

  function automatic int unsigned pick_box(input int unsigned cnt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, cnt);
    if (r < 90) return 0;
    return $urandom_range(0, 2047);
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_MOVE_LEFT;
    if (r < 45) return OP_MOVE_RIGHT;
    if (r < 62) return OP_SWAP;
    if (r < 70) return OP_REVERSE;
    if (r < 94) return OP_QUERY;
    if (r < 97) return OP_RESTART;
    return OpW'($urandom_range(6, 7));
  endfunction

  initial begin
    int unsigned cnt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full line after reset
    send_command(OP_QUERY, 0, 0);
    send_command(OP_MOVE_LEFT, 1, 1024);
    send_command(OP_MOVE_RIGHT, 1024, 1);
    send_command(OP_SWAP, 1, 1024);
    send_command(OP_SWAP, 3, 2);
    send_command(OP_MOVE_LEFT, 5, 6);
    send_command(OP_MOVE_RIGHT, 7, 6);
    send_command(OP_QUERY, 0, 0);
    send_command(OP_REVERSE, 0, 0);
    send_command(OP_MOVE_LEFT, 10, 20);
    send_command(OP_MOVE_RIGHT, 30, 40);
    send_command(OP_QUERY, 0, 0);
    send_command(OP_MOVE_LEFT, 0, 5);
    send_command(OP_SWAP, 5, 2047);
    send_command(OP_MOVE_RIGHT, 9, 9);
    send_command(3'd6, 1, 2);
    send_command(3'd7, 2, 1);
    send_command(OP_QUERY, 0, 0);
    set_box_count(0, 1'b1);
    send_command(OP_QUERY, 0, 0);
    send_command(OP_MOVE_LEFT, 1, 1);
    set_box_count(3, 1'b0);
    send_command(OP_QUERY, 0, 0);
    set_box_count(2047, 1'b1);
    send_command(OP_REVERSE, 0, 0);
    send_command(OP_QUERY, 0, 0);

    // random blocks over idle modes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        cnt = $urandom_range(2, 14);
        if (blk == 4) cnt = (phase == 1) ? 1024 : $urandom_range(1, 40);
        if (phase == 3 && blk == 0) cnt = 1;
        set_box_count(cnt, 1'b1);
        if (phase == 0 && blk == 1) begin
          hold_reqs++;
          repeat (12) send_command(OP_QUERY, 0, 0);
        end
        repeat ((cnt == 1024) ? 8 : 30) send_command(pick_op(), pick_box(cnt), pick_box(cnt));
      end
    end

    in_valid_i <= 1'b0;
    wait (sums_pending == 0);
    repeat (line_count + 50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/lbs_pkg.sv
rtl/linked_box_sequence_engine.sv
rtl/lbs_checker.sv
verif/lbs_sum_checker.sv
verif/tb_linked_box_sequence_engine.sv
